@@ rtl/sset_pkg.sv @@
`default_nettype none
package sset_pkg;
    localparam int COLUMNS_DEF       = 64;
    localparam int MAX_ROWS_DEF      = 256;
    localparam int CAPACITY_DEF      = 1024;
    localparam int DEFAULT_ROWS_DEF  = 64;
    localparam int MIN_ROW_COUNT_DEF = 1;

    localparam int ROW_W   = 8;
    localparam int COL_W   = 6;
    localparam int NROWS_W = 9;
    localparam int COUNT_W = 11;

    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_ERASE = 2'd2;
    localparam logic [1:0] ACT_ROWS  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [7:0] note;
        logic [7:0] instrument;
        logic [7:0] volume;
        logic [7:0] command;
        logic [7:0] effect_param;
        logic [7:0] sign;
        logic       cloned;
    } rec_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [COL_W-1:0]   column;
        logic [ROW_W-1:0]   row;
        logic [NROWS_W-1:0] new_row_count;
        rec_t               rec;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        rec_t               rec;
        logic [COUNT_W-1:0] entry_count;
    } rsp_t;
endpackage
`default_nettype wire

@@ rtl/sset_if.sv @@
`default_nettype none
interface sset_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/sorted_sparse_event_table_unit.sv @@
// Sorted sparse event table: records held in one synchronous memory sorted
// by key row*COLUMNS+column. One item at a time; a binary search (about
// log2(CAPACITY)+1 steps) finds the slot, and an insert or erase then moves
// each later entry one slot through the single memory port. A row shrink
// costs only the search. Reads need only the search and one memory read. The
// result is held in an output register; the next item is taken once it has
// been delivered.
`default_nettype none
module sorted_sparse_event_table_unit
    import sset_pkg::*;
#(
    parameter int COLUMNS       = COLUMNS_DEF,
    parameter int MAX_ROWS      = MAX_ROWS_DEF,
    parameter int CAPACITY      = CAPACITY_DEF,
    parameter int DEFAULT_ROWS  = DEFAULT_ROWS_DEF,
    parameter int MIN_ROW_COUNT = MIN_ROW_COUNT_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    sset_if.sink      in_ch,
    sset_if.source    out_ch
);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int KEY_W = 18;
    localparam logic [3:0] S_IDLE = 4'd0, S_SRCH = 4'd1, S_SWAIT = 4'd2,
        S_DECIDE = 4'd3, S_SHRD = 4'd4, S_SHWAIT = 4'd5, S_SHWR = 4'd6,
        S_PUT = 4'd7, S_RDWAIT = 4'd8, S_DONE = 4'd9;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        rec_t             rec;
    } ent_t;

    ent_t mem [CAPACITY];
    ent_t rd_q;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic             wr_en;
    ent_t             wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_q <= mem[rd_addr];
    end

    logic [3:0]       state_reg;
    req_t             req_reg;
    logic [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0] lo_reg, hi_reg, cur_reg, total_reg;
    logic [NROWS_W-1:0] rows_reg;
    rsp_t             rsp_reg;
    logic             ov_reg;

    logic [CNT_W-1:0] mid;
    logic [KEY_W-1:0] in_key;
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign in_key = KEY_W'(in_ch.data.row) * KEY_W'(COLUMNS) + KEY_W'(in_ch.data.column);

    assign in_ch.ready = (state_reg == S_IDLE) && !ov_reg;
    assign out_ch.valid = ov_reg;
    assign out_ch.data = rsp_reg;

    logic hit;
    assign hit = (lo_reg < total_reg) && (rd_q.key == key_reg);

    always_comb
    begin
        rd_addr = IDX_W'(mid);
        wr_en   = 1'b0;
        wr_addr = IDX_W'(cur_reg);
        wr_data = rd_q;
        unique case (state_reg)
            S_SHRD, S_SHWAIT:
                rd_addr = (req_reg.action == ACT_ERASE) ? IDX_W'(cur_reg + 1'b1)
                                                        : IDX_W'(cur_reg - 1'b1);
            S_SHWR: wr_en = 1'b1;
            S_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = IDX_W'(lo_reg);
                wr_data = '{key: key_reg, rec: req_reg.rec};
            end
            S_DECIDE, S_RDWAIT: rd_addr = IDX_W'(lo_reg);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            rows_reg  <= NROWS_W'(DEFAULT_ROWS);
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_ch.valid && in_ch.ready)
                    begin
                        req_reg <= in_ch.data;
                        rsp_reg <= '0;
                        lo_reg  <= '0;
                        hi_reg  <= total_reg;
                        if (in_ch.data.action == ACT_ROWS)
                        begin
                            key_reg <= KEY_W'(in_ch.data.new_row_count) * KEY_W'(COLUMNS);
                            if (in_ch.data.new_row_count >= NROWS_W'(MIN_ROW_COUNT) &&
                                32'(in_ch.data.new_row_count) <= MAX_ROWS)
                                state_reg <= S_SRCH;
                            else
                                state_reg <= S_DONE;
                        end
                        else if (32'(in_ch.data.column) >= COLUMNS ||
                                 {1'b0, in_ch.data.row} >= rows_reg)
                        begin
                            rsp_reg.status <= ST_RANGE;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            key_reg <= in_key;
                            state_reg <= S_SRCH;
                        end
                    end
                S_SRCH:
                    if (lo_reg < hi_reg)
                        state_reg <= S_SWAIT;
                    else if (req_reg.action == ACT_ROWS)
                    begin
                        if (req_reg.new_row_count < rows_reg)
                            total_reg <= lo_reg;
                        rows_reg  <= req_reg.new_row_count;
                        state_reg <= S_DONE;
                    end
                    else
                        state_reg <= S_DECIDE;
                S_SWAIT:
                begin
                    if (rd_q.key < key_reg)
                        lo_reg <= mid + 1'b1;
                    else
                        hi_reg <= mid;
                    state_reg <= S_SRCH;
                end
                S_DECIDE: state_reg <= S_RDWAIT;
                S_RDWAIT:
                    unique case (req_reg.action)
                        ACT_READ:
                        begin
                            if (hit)
                            begin
                                rsp_reg.found <= 1'b1;
                                rsp_reg.rec   <= rd_q.rec;
                            end
                            state_reg <= S_DONE;
                        end
                        ACT_ERASE:
                            if (hit)
                            begin
                                cur_reg   <= lo_reg;
                                state_reg <= S_SHRD;
                            end
                            else
                                state_reg <= S_DONE;
                        default:
                            if (hit)
                                state_reg <= S_PUT;
                            else if (32'(total_reg) >= CAPACITY)
                            begin
                                rsp_reg.status <= ST_FULL;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                cur_reg   <= total_reg;
                                total_reg <= total_reg + 1'b1;
                                state_reg <= S_SHRD;
                            end
                    endcase
                S_SHRD:
                    if (req_reg.action == ACT_ERASE)
                    begin
                        if (cur_reg + 1'b1 < total_reg)
                            state_reg <= S_SHWAIT;
                        else
                        begin
                            total_reg <= total_reg - 1'b1;
                            state_reg <= S_DONE;
                        end
                    end
                    else if (cur_reg > lo_reg)
                        state_reg <= S_SHWAIT;
                    else
                        state_reg <= S_PUT;
                S_SHWAIT: state_reg <= S_SHWR;
                S_SHWR:
                begin
                    // write lands at cur, then advance toward the tail or head
                    cur_reg <= (req_reg.action == ACT_ERASE) ? cur_reg + 1'b1
                                                             : cur_reg - 1'b1;
                    state_reg <= S_SHRD;
                end
                S_PUT: state_reg <= S_DONE;
                S_DONE:
                    if (!ov_reg)
                    begin
                        rsp_reg.entry_count <= COUNT_W'(total_reg);
                        ov_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ dv/sset_result_monitor.sv @@
`timescale 1ns / 100ps
module sset_result_monitor
    import sset_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_ready,
    input  req_t        req_data,
    input  logic        rsp_valid,
    input  logic        rsp_ready,
    input  rsp_t        rsp_data,
    output int unsigned error_count,
    output int unsigned pending
);
    typedef struct {
        int unsigned key;
        rec_t        rec;
    } table_slot_t;

    table_slot_t sorted_slots[$];
    int unsigned grid_rows;
    rsp_t        expected_rsps[$];
    int unsigned seen_rsps;

    initial
    begin
        error_count = 0;
        grid_rows = DEFAULT_ROWS_DEF;
    end

    assign pending = expected_rsps.size();

    function automatic int unsigned first_not_below(int unsigned k);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = sorted_slots.size();
        while (lo < hi)
        begin
            mid = lo + (hi - lo) / 2;
            if (sorted_slots[mid].key < k)
                lo = mid + 1;
            else
                hi = mid;
        end
        return lo;
    endfunction

    function automatic rsp_t apply_table_item(req_t r);
        rsp_t        rsp;
        int unsigned key;
        int unsigned idx;
        int unsigned cut;
        bit          hit;
        table_slot_t s;
        rsp = '0;
        if (r.action == ACT_ROWS)
        begin
            if (r.new_row_count >= MIN_ROW_COUNT_DEF && r.new_row_count <= MAX_ROWS_DEF)
            begin
                if (r.new_row_count < grid_rows)
                begin
                    cut = first_not_below(r.new_row_count * COLUMNS_DEF);
                    while (sorted_slots.size() > cut)
                        void'(sorted_slots.pop_back());
                end
                grid_rows = r.new_row_count;
            end
        end
        else if (r.column >= COLUMNS_DEF || r.row >= grid_rows)
            rsp.status = ST_RANGE;
        else
        begin
            key = r.row * COLUMNS_DEF + r.column;
            idx = first_not_below(key);
            hit = idx < sorted_slots.size() && sorted_slots[idx].key == key;
            if (r.action == ACT_READ)
            begin
                if (hit)
                begin
                    rsp.found = 1'b1;
                    rsp.rec = sorted_slots[idx].rec;
                end
            end
            else if (r.action == ACT_ERASE)
            begin
                if (hit)
                    sorted_slots.delete(idx);
            end
            else
            begin
                s.key = key;
                s.rec = r.rec;
                if (hit)
                    sorted_slots[idx] = s;
                else if (sorted_slots.size() >= CAPACITY_DEF)
                    rsp.status = ST_FULL;
                else
                    sorted_slots.insert(idx, s);
            end
        end
        rsp.entry_count = COUNT_W'(sorted_slots.size());
        return rsp;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch on result %0d: %s got %0h want %0h", seen_rsps, what, got, want);
        error_count++;
    endtask

    task automatic compare_rsp(rsp_t got);
        rsp_t want;
        if (expected_rsps.size() == 0)
        begin
            $display("unexpected result transfer %0d", seen_rsps);
            error_count++;
            return;
        end
        want = expected_rsps.pop_front();
        if (got.status !== want.status)
            report_mismatch("status", got.status, want.status);
        if (got.found !== want.found)
            report_mismatch("found", got.found, want.found);
        if (got.rec.note !== want.rec.note)
            report_mismatch("note", got.rec.note, want.rec.note);
        if (got.rec.instrument !== want.rec.instrument)
            report_mismatch("instrument", got.rec.instrument, want.rec.instrument);
        if (got.rec.volume !== want.rec.volume)
            report_mismatch("volume", got.rec.volume, want.rec.volume);
        if (got.rec.command !== want.rec.command)
            report_mismatch("command", got.rec.command, want.rec.command);
        if (got.rec.effect_param !== want.rec.effect_param)
            report_mismatch("parameter", got.rec.effect_param, want.rec.effect_param);
        if (got.rec.sign !== want.rec.sign)
            report_mismatch("sign", got.rec.sign, want.rec.sign);
        if (got.rec.cloned !== want.rec.cloned)
            report_mismatch("cloned", got.rec.cloned, want.rec.cloned);
        if (got.entry_count !== want.entry_count)
            report_mismatch("entry_count", got.entry_count, want.entry_count);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                expected_rsps.push_back(apply_table_item(req_data));
            if (rsp_valid && rsp_ready)
            begin
                compare_rsp(rsp_data);
                seen_rsps++;
            end
        end
    end
endmodule

@@ dv/sorted_sparse_event_table_unit_test.sv @@
`timescale 1ns / 100ps
module sorted_sparse_event_table_unit_test;
    import sset_pkg::*;

    logic        clk;
    logic        rst_n;
    int unsigned error_count;
    int unsigned pending;
    int unsigned send_idle_pct;
    int unsigned sink_stall_pct;

    sset_if #(.payload_t(req_t)) req_ch ();
    sset_if #(.payload_t(rsp_t)) rsp_ch ();

    sorted_sparse_event_table_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_ch),
        .out_ch (rsp_ch)
    );

    sset_result_monitor monitor (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_ch.valid),
        .req_ready   (req_ch.ready),
        .req_data    (req_ch.data),
        .rsp_valid   (rsp_ch.valid),
        .rsp_ready   (rsp_ch.ready),
        .rsp_data    (rsp_ch.data),
        .error_count (error_count),
        .pending     (pending)
    );

    initial
        clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(negedge clk)
        rsp_ch.ready = rst_n && ($urandom_range(0, 99) >= sink_stall_pct);

    function automatic rec_t random_rec();
        rec_t r;
        r.note = 8'($urandom);
        r.instrument = 8'($urandom);
        r.volume = 8'($urandom);
        r.command = 8'($urandom);
        r.effect_param = 8'($urandom);
        r.sign = 8'($urandom);
        r.cloned = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic req_t make_req(logic [1:0] act, int unsigned row, int unsigned col,
                                      int unsigned nrows, rec_t r);
        req_t q;
        q.action = act;
        q.row = ROW_W'(row);
        q.column = COL_W'(col);
        q.new_row_count = NROWS_W'(nrows);
        q.rec = r;
        return q;
    endfunction

    // Hold valid until the transfer, called at a falling edge.
    task automatic send_item(req_t q);
        bit took;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid = 1'b0;
            req_ch.data = req_t'($urandom);
            @(negedge clk);
        end
        req_ch.valid = 1'b1;
        req_ch.data = q;
        do
        begin
            @(posedge clk);
            took = req_ch.ready;
            @(negedge clk);
        end
        while (!took);
        req_ch.valid = 1'b0;
    endtask

    task automatic send_random_item();
        logic [1:0]  act;
        int unsigned pick;
        int unsigned row;
        int unsigned col;
        int unsigned nrows;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            act = ACT_READ;
        else if (pick < 72)
            act = ACT_WRITE;
        else if (pick < 90)
            act = ACT_ERASE;
        else
            act = ACT_ROWS;
        row = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 255);
        col = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 7) : $urandom_range(0, 63);
        pick = $urandom_range(0, 9);
        if (pick < 6)
            nrows = $urandom_range(1, 8);
        else if (pick < 8)
            nrows = $urandom_range(1, 256);
        else
            nrows = $urandom_range(0, 511);
        send_item(make_req(act, row, col, nrows, random_rec()));
    endtask

    rec_t ones_rec;
    int   phase;

    initial
    begin
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        rsp_ch.ready = 1'b0;
        send_idle_pct = 0;
        sink_stall_pct = 0;
        ones_rec = '1;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed corners with the default row count.
        send_item(make_req(ACT_READ, 0, 0, 0, random_rec()));
        send_item(make_req(ACT_WRITE, 0, 0, 0, ones_rec));
        send_item(make_req(ACT_READ, 0, 0, 0, '0));
        send_item(make_req(ACT_WRITE, 63, 63, 0, '0));
        send_item(make_req(ACT_READ, 63, 63, 0, '0));
        send_item(make_req(ACT_WRITE, 64, 5, 0, ones_rec));
        send_item(make_req(ACT_READ, 255, 63, 0, '0));
        send_item(make_req(ACT_ERASE, 200, 1, 0, '0));
        send_item(make_req(ACT_ERASE, 3, 3, 0, '0));
        send_item(make_req(ACT_ERASE, 63, 63, 0, '0));
        send_item(make_req(ACT_READ, 63, 63, 0, '0));
        send_item(make_req(ACT_ROWS, 0, 0, 0, '0));
        send_item(make_req(ACT_ROWS, 0, 0, 257, '0));
        send_item(make_req(ACT_ROWS, 0, 0, 511, '0));
        send_item(make_req(ACT_ROWS, 0, 0, 256, '0));
        send_item(make_req(ACT_WRITE, 255, 63, 0, ones_rec));
        send_item(make_req(ACT_READ, 255, 63, 0, '0));
        send_item(make_req(ACT_WRITE, 255, 63, 0, random_rec()));
        send_item(make_req(ACT_ROWS, 0, 0, 1, '0));
        send_item(make_req(ACT_READ, 0, 0, 0, '0));
        send_item(make_req(ACT_ROWS, 0, 0, 64, '0));

        // Fill the table in key order, then overflow it.
        for (int k = 0; k < CAPACITY_DEF; k++)
            send_item(make_req(ACT_WRITE, k / COLUMNS_DEF, k % COLUMNS_DEF, 0, random_rec()));
        send_item(make_req(ACT_WRITE, 20, 0, 0, random_rec()));
        send_item(make_req(ACT_WRITE, 0, 5, 0, ones_rec));
        send_item(make_req(ACT_READ, 0, 5, 0, '0));
        send_item(make_req(ACT_ROWS, 0, 0, 8, '0));
        send_item(make_req(ACT_ERASE, 0, 0, 0, '0));
        send_item(make_req(ACT_ROWS, 0, 0, 1, '0));
        send_item(make_req(ACT_ROWS, 0, 0, 64, '0));

        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                1: begin send_idle_pct = 61; sink_stall_pct = 0; end
                2: begin send_idle_pct = 0; sink_stall_pct = 61; end
                3: begin send_idle_pct = 13; sink_stall_pct = 13; end
                default: begin send_idle_pct = 0; sink_stall_pct = 0; end
            endcase
            repeat (116) send_random_item();
        end

        while (pending != 0)
            @(negedge clk);
        repeat (2200) @(negedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
